// ===== rtl/core/fpa_pkg.sv =====
// Shared types and constants for the fit policy partition allocator.
package fpa_pkg;

    // Default number of table blocks.
    localparam int BLOCKS_DEF = 16;

    // Largest number of blocks that loads can address.
    localparam int ADDR_BLOCKS = 16;

    // Width of the request size and leftover fields.
    localparam int SIZE_W = 32;

    // Width of the block count register.
    localparam int COUNT_W = 5;

    // Configuration register indexes.
    localparam logic CFG_FIT_MODE    = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    // Placement policies; the unused code behaves as first fit.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Request operations.
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ALLOC   = 2'd2,
        OP_NONE    = 2'd3
    } fpa_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       exec;
        logic       rd_en;
        logic [3:0] rd_addr;
        logic       finish;
    } fpa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        fpa_op_t op;
        logic    out_free;
    } fpa_status_t;

endpackage

// ===== rtl/core/fpa_req_if.sv =====
// Request channel carrying one allocator operation.
interface fpa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  block_index;
    logic [31:0] size_value;

    modport source (output valid, output op, output block_index, output size_value,
                    input ready);
    modport sink (input valid, input op, input block_index, input size_value,
                  output ready);
endinterface

// ===== rtl/core/fpa_rsp_if.sv =====
// Response channel carrying one allocator result.
interface fpa_rsp_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [3:0]  chosen_block;
    logic [31:0] leftover;

    modport source (output valid, output granted, output chosen_block, output leftover,
                    input ready);
    modport sink (input valid, input granted, input chosen_block, input leftover,
                  output ready);
endinterface

// ===== rtl/core/fit_policy_partition_allocator.sv =====
// Top level of the fixed-partition allocator with selectable fit policy.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    op, block_index, size_value
//   rsp      out  valid/ready    granted, chosen_block, leftover
//   cfg      in   cfg_we         cfg_index, cfg_data (fit_mode, block_count)
//
// Load, release and unused ops, and an allocate with nothing to scan, pass from the idle
// state that accepts the request through the execute state to the writeback state, which
// presents the result. Any other allocate goes from the execute state to the scan state,
// which reads n = min(block_count, BLOCKS, 16) entries, one table read per cycle through a
// single compare unit, then through a drain state to the writeback state.
// Reset clears the taken flags, the config registers and the control state; the
// size table holds no reset value. A stalled response holds the sequencer in its
// writeback state; a new request is accepted once the previous one is written back.
module fit_policy_partition_allocator #(
    parameter int BLOCKS = fpa_pkg::BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fpa_req_if.sink                     req,
    fpa_rsp_if.source                   rsp,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [fpa_pkg::COUNT_W-1:0] cfg_data
);
    import fpa_pkg::*;

    localparam int LIM = (BLOCKS < ADDR_BLOCKS) ? BLOCKS : ADDR_BLOCKS;

    logic [1:0]         fit_mode_reg;
    logic [COUNT_W-1:0] block_count_reg;
    logic [COUNT_W-1:0] limit;
    fpa_cmd_t           cmd;
    fpa_status_t        status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= FIT_FIRST;
            block_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIT_MODE:    fit_mode_reg    <= cfg_data[1:0];
                CFG_BLOCK_COUNT: block_count_reg <= cfg_data;
                default:         fit_mode_reg    <= fit_mode_reg;
            endcase
        end
    end

    // Number of entries an allocate scans.
    assign limit = (block_count_reg > COUNT_W'(LIM)) ? COUNT_W'(LIM) : block_count_reg;

    // Sequencer.
    fpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .limit     (limit),
        .status    (status),
        .cmd       (cmd)
    );

    // Table and compare datapath.
    fpa_datapath #(
        .BLOCKS (BLOCKS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .fit_mode (fit_mode_reg),
        .in_op    (req.op),
        .in_index (req.block_index),
        .in_size  (req.size_value),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/core/fpa_datapath.sv =====
// Block table, scan compare unit and result register of the allocator.
module fpa_datapath #(
    parameter int BLOCKS = fpa_pkg::BLOCKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fpa_pkg::fpa_cmd_t   cmd,
    output fpa_pkg::fpa_status_t status,
    input  logic [1:0]          fit_mode,
    input  logic [1:0]          in_op,
    input  logic [3:0]          in_index,
    input  logic [31:0]         in_size,
    fpa_rsp_if.source           rsp
);
    import fpa_pkg::*;

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    // Captured request.
    fpa_op_t            op_reg;
    logic [3:0]         idx_reg;
    logic [SIZE_W-1:0]  size_reg;

    // Block table and taken flags.
    logic [SIZE_W-1:0]  size_mem [BLOCKS];
    logic [BLOCKS-1:0]  taken_reg;

    // Registered read of the entry under scan.
    logic [SIZE_W-1:0]  rd_size_reg;
    logic               rd_taken_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               cmp_en_reg;

    // Best candidate so far.
    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [SIZE_W-1:0]  best_size_reg;

    // Result register.
    logic               out_valid_reg;
    logic               out_granted_reg;
    logic [3:0]         out_block_reg;
    logic [SIZE_W-1:0]  out_left_reg;

    logic               load_hit;
    logic               cand;
    logic               take;
    logic               grant;
    logic [IDX_W-1:0]   load_addr;
    logic [IDX_W-1:0]   scan_addr;

    assign load_addr = IDX_W'(idx_reg);
    assign scan_addr = IDX_W'(cmd.rd_addr);
    assign load_hit  = (32'(idx_reg) < 32'(BLOCKS));

    // A free block that is large enough replaces the current pick by policy.
    assign cand  = cmp_en_reg && !rd_taken_reg && (rd_size_reg >= size_reg);
    assign take  = cand && (!found_reg
                   || ((fit_mode == FIT_BEST) && (rd_size_reg < best_size_reg))
                   || ((fit_mode == FIT_WORST) && (rd_size_reg > best_size_reg)));
    assign grant = (op_reg == OP_ALLOC) && found_reg;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= fpa_op_t'(in_op);
            idx_reg  <= in_index;
            size_reg <= in_size;
        end
    end

    // Table write on load and registered read during the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && (op_reg == OP_LOAD) && load_hit)
        begin
            size_mem[load_addr] <= size_reg;
        end
        if (cmd.rd_en)
        begin
            rd_size_reg  <= size_mem[scan_addr];
            rd_taken_reg <= taken_reg[scan_addr];
            rd_idx_reg   <= scan_addr;
        end
    end

    // Taken flags: cleared by load and release, set by a grant.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else if (cmd.exec && (op_reg == OP_LOAD) && load_hit)
        begin
            taken_reg[load_addr] <= 1'b0;
        end
        else if (cmd.exec && (op_reg == OP_RELEASE))
        begin
            taken_reg <= '0;
        end
        else if (cmd.finish && grant)
        begin
            taken_reg[best_idx_reg] <= 1'b1;
        end
    end

    // Compare stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_en_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.rd_en;
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Best candidate payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg  <= rd_idx_reg;
            best_size_reg <= rd_size_reg;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; zero unless an allocate found a block.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_granted_reg <= grant;
            out_block_reg   <= grant ? 4'(best_idx_reg) : 4'd0;
            out_left_reg    <= grant ? (best_size_reg - size_reg) : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted      = out_granted_reg;
    assign rsp.chosen_block = out_block_reg;
    assign rsp.leftover     = out_left_reg;

    assign status.op       = op_reg;
    assign status.out_free = !out_valid_reg || rsp.ready;

    // A held pick always fits the request it was chosen for.
    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_size_reg >= size_reg))
        else $error("picked block smaller than request");

    // A grant marks the chosen block taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && grant) |=> taken_reg[$past(best_idx_reg)])
        else $error("granted block not marked taken");

    // A result is only produced when the output slot can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || rsp.ready))
        else $error("result overwritten before delivery");

endmodule

// ===== rtl/core/fpa_ctrl.sv =====
// Sequencer for request capture, table scan and result writeback.
module fpa_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [fpa_pkg::COUNT_W-1:0] limit,
    input  fpa_pkg::fpa_status_t        status,
    output fpa_pkg::fpa_cmd_t           cmd
);
    import fpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic [COUNT_W-1:0] cnt_inc;

    assign cnt_inc = cnt_reg + COUNT_W'(1);

    // Next state and scan counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cnt_next = '0;
                if ((status.op == OP_ALLOC) && (limit != '0))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc == limit)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Commands decoded from the state.
    assign req_ready   = (state_reg == S_IDLE);
    assign cmd.capture = req_ready && req_valid;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.rd_en   = (state_reg == S_SCAN);
    assign cmd.rd_addr = cnt_reg[3:0];
    assign cmd.finish  = (state_reg == S_FINISH) && status.out_free;

    // Reads stay inside the scanned range.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (cnt_reg < limit))
        else $error("scan read beyond block limit");

    // An accepted request is executed in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (cmd.exec && !req_ready))
        else $error("captured request not executed");

    // Writeback returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> req_ready)
        else $error("no return to idle after writeback");

endmodule

// ===== bench/allocation_checker.sv =====
// Checker that predicts and compares every allocator response.
`timescale 1ns / 1ps

module allocation_checker #(
    parameter int BLOCKS = fpa_pkg::BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fpa_req_if                          req,
    fpa_rsp_if                          rsp,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [fpa_pkg::COUNT_W-1:0] cfg_data,
    output int                          pending,
    output int                          failures
);
    import fpa_pkg::*;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_block;
        logic [31:0] leftover;
    } grant_t;

    // Private copy of the partition table and the policy registers.
    logic [SIZE_W-1:0]  part_size [BLOCKS];
    bit                 part_taken [BLOCKS];
    logic [1:0]         policy;
    logic [COUNT_W-1:0] part_count;

    grant_t expected_grants [$];
    int     mismatches = 0;

    assign failures = mismatches;

    // Apply one request to the private table and queue the response it must produce.
    task automatic predict_allocation(input fpa_op_t op, input logic [3:0] slot,
                                      input logic [SIZE_W-1:0] size);
        grant_t res;
        int     limit;
        int     pick;
        bit     found;
        res = '0;
        pick = 0;
        found = 1'b0;
        case (op)
            OP_LOAD:
            begin
                if (slot < BLOCKS)
                begin
                    part_size[slot] = size;
                    part_taken[slot] = 1'b0;
                end
            end
            OP_RELEASE:
            begin
                foreach (part_taken[i])
                    part_taken[i] = 1'b0;
            end
            OP_ALLOC:
            begin
                // Only the first block_count entries take part, capped by the table size and by ADDR_BLOCKS.
                limit = (part_count > BLOCKS) ? BLOCKS : part_count;
                if (limit > ADDR_BLOCKS)
                    limit = ADDR_BLOCKS;
                for (int j = 0; j < limit; j++)
                begin
                    if (!part_taken[j] && part_size[j] >= size)
                    begin
                        if (!found)
                        begin
                            found = 1'b1;
                            pick = j;
                            // First fit (and the unused code) stops at the first candidate.
                            if (policy != FIT_BEST && policy != FIT_WORST)
                                break;
                        end
                        else if (policy == FIT_BEST && part_size[j] < part_size[pick])
                            pick = j;
                        else if (policy == FIT_WORST && part_size[j] > part_size[pick])
                            pick = j;
                    end
                end
                if (found)
                begin
                    part_taken[pick] = 1'b1;
                    res.granted = 1'b1;
                    res.chosen_block = pick[3:0];
                    res.leftover = part_size[pick] - size;
                end
            end
            default: ;
        endcase
        expected_grants.push_back(res);
    endtask

    // Compare one accepted response with the oldest expectation.
    task automatic compare_response();
        grant_t want;
        if (expected_grants.size() == 0)
        begin
            $display("%0t: response with nothing expected: granted %0b block %0d leftover %0h",
                     $time, rsp.granted, rsp.chosen_block, rsp.leftover);
            mismatches++;
        end
        else
        begin
            want = expected_grants.pop_front();
            if (rsp.granted !== want.granted)
            begin
                $display("%0t: granted expected %0b actual %0b",
                         $time, want.granted, rsp.granted);
                mismatches++;
            end
            if (rsp.chosen_block !== want.chosen_block)
            begin
                $display("%0t: chosen_block expected %0d actual %0d",
                         $time, want.chosen_block, rsp.chosen_block);
                mismatches++;
            end
            if (rsp.leftover !== want.leftover)
            begin
                $display("%0t: leftover expected %0h actual %0h",
                         $time, want.leftover, rsp.leftover);
                mismatches++;
            end
        end
    endtask

    // Watch the register port and both channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (part_taken[i])
                part_taken[i] = 1'b0;
            policy = FIT_FIRST;
            part_count = '0;
            expected_grants.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FIT_MODE)
                    policy = cfg_data[1:0];
                else
                    part_count = cfg_data;
            end
            if (rsp.valid && rsp.ready)
                compare_response();
            if (req.valid && req.ready)
                predict_allocation(fpa_op_t'(req.op), req.block_index, req.size_value);
            pending <= expected_grants.size();
        end
    end

endmodule

// ===== bench/fit_policy_partition_allocator_test.sv =====
// Top of the allocator testbench: clock, reset, stimulus, response pacing and verdict.
`timescale 1ns / 1ps

module fit_policy_partition_allocator_test;
    import fpa_pkg::*;

    localparam logic [1:0] FIT_UNUSED = 2'd3;
    localparam int PHASES = 14;
    localparam int PHASE_ITEMS = 125;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [COUNT_W-1:0] cfg_data;
    int                 pending;
    int                 failures;
    bit                 valid_burst;
    bit                 ready_burst;
    logic [COUNT_W-1:0] active_count;

    fpa_req_if req_bus ();
    fpa_rsp_if rsp_bus ();

    fit_policy_partition_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    allocation_checker alloc_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .failures  (failures)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #15_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Offer one request, after a random gap unless in a valid burst, and hold it until it is accepted.
    task automatic send_request(input fpa_op_t op, input logic [3:0] slot,
                                input logic [SIZE_W-1:0] size);
        int gap;
        gap = valid_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.op <= op;
        req_bus.block_index <= slot;
        req_bus.size_value <= size;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected response has come back.
    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Write both registers; the upper bits of the mode write are don't-care.
    task automatic set_policy(input logic [1:0] mode, input logic [COUNT_W-1:0] count);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FIT_MODE;
        cfg_data <= {3'($urandom_range(0, 7)), mode};
        @(posedge clk);
        cfg_index <= CFG_BLOCK_COUNT;
        cfg_data <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_count = count;
    endtask

    // Sizes cluster on small values so that ties and near misses are common.
    function automatic logic [SIZE_W-1:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom_range(0, 15);
        else if (pick < 70)
            return $urandom_range(0, 1000);
        else if (pick < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // One random request: mostly allocations and loads, with releases and unused ops.
    task automatic random_request();
        int         pick;
        logic [3:0] slot;
        pick = $urandom_range(0, 99);
        if (active_count > 0 && $urandom_range(0, 9) < 7)
            slot = 4'($urandom_range(0, (active_count > 16) ? 15 : active_count - 1));
        else
            slot = 4'($urandom_range(0, 15));
        if (pick < 55)
            send_request(OP_ALLOC, 4'($urandom_range(0, 15)), random_size());
        else if (pick < 85)
            send_request(OP_LOAD, slot, random_size());
        else if (pick < 95)
            send_request(OP_RELEASE, 4'($urandom_range(0, 15)), $urandom);
        else
            send_request(OP_NONE, 4'($urandom_range(0, 15)), $urandom);
    endtask

    // Directed opening: empty table, full table load, ties and extremes in the unused, best and worst fit policies.
    task automatic run_directed();
        logic [SIZE_W-1:0] preset [16];
        preset = '{32'd1000, 32'd0, 32'd250, 32'd4000, 32'd250, 32'hFFFF_FFFF, 32'd600,
                   32'd4000, 32'd1, 32'd1000, 32'd250, 32'd70000, 32'd3, 32'h8000_0000,
                   32'd999, 32'd4000};
        valid_burst = 1'b0;
        ready_burst = 1'b0;
        // Nothing is scanned with the reset block count.
        send_request(OP_ALLOC, 4'd0, 32'd5);
        for (int i = 0; i < 16; i++)
            send_request(OP_LOAD, i[3:0], preset[i]);
        send_request(OP_NONE, 4'd9, 32'hA5A5_5A5A);
        // Oversized count with the unused policy code.
        wait_for_results();
        set_policy(FIT_UNUSED, 5'd31);
        send_request(OP_ALLOC, 4'd0, 32'd0);
        send_request(OP_ALLOC, 4'd0, 32'hFFFF_FFFF);
        // Best fit with a three-way tie.
        wait_for_results();
        set_policy(FIT_BEST, 5'd16);
        send_request(OP_ALLOC, 4'd0, 32'd250);
        send_request(OP_ALLOC, 4'd0, 32'd250);
        // Worst fit, including a request that nothing can hold.
        wait_for_results();
        set_policy(FIT_WORST, 5'd16);
        send_request(OP_ALLOC, 4'd0, 32'd0);
        send_request(OP_ALLOC, 4'd0, 32'd5000);
        send_request(OP_ALLOC, 4'd0, 32'h9000_0000);
        send_request(OP_RELEASE, 4'd15, 32'hFFFF_FFFF);
    endtask

    // Response side: random stalls, sometimes held until a response is offered.
    initial
    begin
        int stall;
        rsp_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = ready_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                if ($urandom_range(0, 1))
                begin
                    @(posedge clk);
                    while (!rsp_bus.valid)
                        @(posedge clk);
                end
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_bus.valid)
                @(posedge clk);
        end
    end

    // Request side: reset, directed part, then phases of random traffic.
    initial
    begin
        logic [1:0]         mode;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] count_plan [6];
        count_plan = '{5'd16, 5'd16, 5'd16, 5'd31, 5'd0, 5'd1};
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_FIT_MODE;
        cfg_data <= '0;
        req_bus.valid <= 1'b0;
        req_bus.op <= OP_NONE;
        req_bus.block_index <= '0;
        req_bus.size_value <= '0;
        active_count = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            // The early phases pin every policy and the count extremes.
            if (phase < 6)
            begin
                mode = phase[1:0];
                count = count_plan[phase];
            end
            else
            begin
                mode = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0: count = 5'd0;
                    1, 2: count = 5'($urandom_range(17, 31));
                    default: count = 5'($urandom_range(1, 16));
                endcase
            end
            set_policy(mode, count);
            valid_burst = (phase % 3 == 2);
            ready_burst = (phase % 4 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_request();
                if ($urandom_range(0, 49) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (25) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
